### hw/rtl/timer_bank_with_round_robin_dispatch_assert.svh
// ----------------------------------------------------------------------------
// Timer bank assertion macros
// Shorthand for the clocked, reset-qualified checks of the timer bank.
// ----------------------------------------------------------------------------
`ifndef TIMER_BANK_WITH_ROUND_ROBIN_DISPATCH_ASSERT_SVH
`define TIMER_BANK_WITH_ROUND_ROBIN_DISPATCH_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TBRR_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("timer bank check failed");

// The consequent holds in the cycle after the antecedent.
`define TBRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("timer bank check failed");

`endif

### hw/rtl/tbrr_pkg.sv
// ----------------------------------------------------------------------------
// Timer bank package
// Operation codes of the timer bank, and the timer and slot widths shared by the word interfaces and the timer bank.
// ----------------------------------------------------------------------------
package tbrr_pkg;

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_ADD      = 3'd1,
    MODE_CHANGE   = 3'd2,
    MODE_STOP     = 3'd3,
    MODE_START    = 3'd4,
    MODE_DISPATCH = 3'd5
  } mode_t;

  localparam int TIMER_W = 16;
  localparam int SLOT_W  = 5;

endpackage

### hw/rtl/tbrr_in_if.sv
// ----------------------------------------------------------------------------
// Timer bank request interface
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface tbrr_in_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  mode;
  logic [4:0]                  timer_index;
  logic [tbrr_pkg::TIMER_W-1:0] period;
  logic                        repeat_req;

  modport source (output valid, mode, timer_index, period, repeat_req, input ready);
  modport sink (input valid, mode, timer_index, period, repeat_req, output ready);
endinterface

### hw/rtl/tbrr_out_if.sv
// ----------------------------------------------------------------------------
// Timer bank response interface
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface tbrr_out_if;
  logic                        valid;
  logic                        ready;
  logic [tbrr_pkg::SLOT_W-1:0] slot;
  logic                        ok;

  modport source (output valid, slot, ok, input ready);
  modport sink (input valid, slot, ok, output ready);
endinterface

### hw/rtl/timer_bank_with_round_robin_dispatch.sv
// ----------------------------------------------------------------------------
// Timer bank with round-robin dispatch
// Periodic and one-shot timers whose counters and periods live in two
// synchronous memories, swept slot by slot for tick and add.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   mode, timer_index, period, repeat_req
//  rsp      out  slot, ok
//
//  Tick and add sweep the used slots through the memory read port; add then
//  does its phase reduction in S_ADDFIX and writes the new slot in S_ADDWR.
//  Dispatch checks one pending bit per cycle, at most used_count slots.
//  Change, stop and start pass from idle to done. One word is worked at a time.
//  Synchronous reset clears the used count, pointer, enable and pending bits.
//  A stalled response holds the bank in its final state until taken.
module timer_bank_with_round_robin_dispatch #(
  parameter int NUM_TIMERS = 32
) (
  input logic  clk,
  input logic  rst,
  tbrr_in_if.sink   req,
  tbrr_out_if.source rsp
);

  localparam int IDX_W = $clog2(NUM_TIMERS);
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);
  localparam int TW    = tbrr_pkg::TIMER_W;
  localparam int SW    = tbrr_pkg::SLOT_W;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TICK   = 7'b0000010,
    S_ADD    = 7'b0000100,
    S_ADDFIX = 7'b0001000,
    S_ADDWR  = 7'b0010000,
    S_DISP   = 7'b0100000,
    S_DONE   = 7'b1000000
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      used_count;
  logic [IDX_W-1:0]      scan_ptr;
  logic [NUM_TIMERS-1:0] en_bits;
  logic [NUM_TIMERS-1:0] rep_bits;
  logic [NUM_TIMERS-1:0] pend_bits;
  logic                  op_tick;
  logic [TW-1:0]         op_per;
  logic                  op_rep;
  logic [CNT_W-1:0]      issue;
  logic                  p_vld;
  logic [IDX_W-1:0]      p_idx;
  logic                  match;
  logic [TW:0]           nx;
  logic [TW:0]           red;
  logic [CNT_W-1:0]      step;
  logic [SW-1:0]         res_slot;
  logic                  res_ok;
  logic                  ov;
  logic [SW-1:0]         out_slot;
  logic                  out_ok;

  logic [TW-1:0] cnt_mem [NUM_TIMERS];
  logic [TW-1:0] per_mem [NUM_TIMERS];
  logic [TW-1:0] cnt_rd;
  logic [TW-1:0] per_rd;

  logic             acc;
  logic             idx_ok;
  logic [IDX_W-1:0] req_idx;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             we_cnt;
  logic             we_per;
  logic [IDX_W-1:0] wr_addr;
  logic [TW-1:0]    wd_cnt;
  logic [TW-1:0]    wd_per;
  logic [TW-1:0]    tick_inc;
  logic             tick_hit;
  logic [TW:0]      per_ext;
  logic [TW:0]      red2;
  logic [TW-1:0]    add_start;
  logic [CNT_W-1:0] ptr_inc;
  logic [IDX_W-1:0] nptr;

  assign acc      = req.valid && req.ready;
  assign idx_ok   = ({3'b000, req.timer_index} < 8'(used_count));
  assign req_idx  = IDX_W'(req.timer_index);
  assign rd_en    = ((state == S_TICK) || (state == S_ADD)) && (issue < used_count);
  assign rd_addr  = issue[IDX_W-1:0];
  assign tick_inc = cnt_rd + 16'd1;
  assign tick_hit = (tick_inc == per_rd);
  assign per_ext  = {1'b0, op_per};
  assign red2     = (red >= per_ext) ? (red - per_ext) : red;
  assign ptr_inc  = CNT_W'(scan_ptr) + 1'b1;
  assign nptr     = (ptr_inc == used_count) ? '0 : ptr_inc[IDX_W-1:0];

  always_comb begin
    if (!match) begin
      add_start = op_per - 16'd1;
    end else if (op_per == '0) begin
      add_start = nx[TW-1:0];
    end else begin
      add_start = red2[TW-1:0];
    end
  end

  always_comb begin
    we_cnt  = 1'b0;
    we_per  = 1'b0;
    wr_addr = req_idx;
    wd_cnt  = '0;
    wd_per  = req.period;
    if (state == S_IDLE) begin
      if (acc && idx_ok) begin
        we_cnt = (req.mode == tbrr_pkg::MODE_CHANGE) || (req.mode == tbrr_pkg::MODE_START);
        we_per = (req.mode == tbrr_pkg::MODE_CHANGE);
      end
    end else if (state == S_TICK) begin
      wr_addr = p_idx;
      we_cnt  = p_vld && en_bits[p_idx];
      wd_cnt  = (tick_hit && rep_bits[p_idx]) ? '0 : tick_inc;
    end else if (state == S_ADDWR) begin
      wr_addr = used_count[IDX_W-1:0];
      we_cnt  = 1'b1;
      we_per  = 1'b1;
      wd_cnt  = add_start;
      wd_per  = op_per;
    end
  end

  always_ff @(posedge clk) begin
    if (we_cnt) begin
      cnt_mem[wr_addr] <= wd_cnt;
    end
    if (we_per) begin
      per_mem[wr_addr] <= wd_per;
    end
    if (rd_en) begin
      cnt_rd <= cnt_mem[rd_addr];
      per_rd <= per_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used_count <= '0;
      scan_ptr   <= '0;
      en_bits    <= '0;
      pend_bits  <= '0;
      p_vld      <= 1'b0;
      ov         <= 1'b0;
    end else begin
      if ((state == S_DONE) && (!ov || rsp.ready)) begin
        ov       <= 1'b1;
        out_slot <= res_slot;
        out_ok   <= res_ok;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            res_slot <= '0;
            res_ok   <= 1'b0;
            issue    <= '0;
            p_vld    <= 1'b0;
            match    <= 1'b0;
            step     <= '0;
            op_per   <= req.period;
            op_rep   <= req.repeat_req;
            op_tick  <= (req.mode == tbrr_pkg::MODE_TICK);
            state    <= S_DONE;
            case (req.mode)
              tbrr_pkg::MODE_TICK: begin
                res_ok <= 1'b1;
                state  <= S_TICK;
              end
              tbrr_pkg::MODE_ADD: begin
                if (used_count != CNT_W'(NUM_TIMERS)) begin
                  state <= S_ADD;
                end
              end
              tbrr_pkg::MODE_CHANGE: begin
                res_ok <= idx_ok;
              end
              tbrr_pkg::MODE_STOP: begin
                res_ok <= idx_ok;
                if (idx_ok) begin
                  en_bits[req_idx] <= 1'b0;
                end
              end
              tbrr_pkg::MODE_START: begin
                res_ok <= idx_ok;
                if (idx_ok) begin
                  en_bits[req_idx] <= 1'b1;
                end
              end
              tbrr_pkg::MODE_DISPATCH: begin
                if (used_count != '0) begin
                  state <= S_DISP;
                end
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_TICK, S_ADD: begin
          issue <= issue + CNT_W'(rd_en);
          p_vld <= rd_en;
          p_idx <= rd_addr;
          if (p_vld) begin
            if (op_tick) begin
              if (en_bits[p_idx] && tick_hit) begin
                pend_bits[p_idx] <= 1'b1;
                if (!rep_bits[p_idx]) begin
                  en_bits[p_idx] <= 1'b0;
                end
              end
            end else if (per_rd == op_per) begin
              match <= 1'b1;
              nx    <= {1'b0, cnt_rd} + 17'd1;
            end
          end
          if (!rd_en && !p_vld) begin
            state <= op_tick ? S_DONE : S_ADDFIX;
          end
        end
        S_ADDFIX: begin
          red   <= (nx >= per_ext) ? (nx - per_ext) : nx;
          state <= S_ADDWR;
        end
        S_ADDWR: begin
          en_bits[used_count[IDX_W-1:0]]  <= op_rep;
          rep_bits[used_count[IDX_W-1:0]] <= op_rep;
          used_count <= used_count + 1'b1;
          res_slot   <= SW'(used_count);
          res_ok     <= 1'b1;
          state      <= S_DONE;
        end
        S_DISP: begin
          scan_ptr <= nptr;
          step     <= step + 1'b1;
          if (pend_bits[nptr]) begin
            pend_bits[nptr] <= 1'b0;
            res_slot <= SW'(nptr);
            res_ok   <= 1'b1;
            state    <= S_DONE;
          end else if ((step + 1'b1) == used_count) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ov || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = ov;
  assign rsp.slot  = out_slot;
  assign rsp.ok    = out_ok;

`include "timer_bank_with_round_robin_dispatch_assert.svh"

  `TBRR_ASSERT_NEXT(a_one_word, clk, rst, acc, !req.ready)
  `TBRR_ASSERT_SAME(a_used_bound, clk, rst, 1'b1, used_count <= CNT_W'(NUM_TIMERS))
  `TBRR_ASSERT_SAME(a_ptr_bound, clk, rst, used_count != '0, CNT_W'(scan_ptr) < used_count)

endmodule
